@@ hdl/pixel_tone_gray_blend_assert.svh @@
// Assertion macros for the pixel tone and gray blend block.
// Included by pixel_tone_gray_blend; depends on nothing else.
`ifndef PIXEL_TONE_GRAY_BLEND_ASSERT_SVH
`define PIXEL_TONE_GRAY_BLEND_ASSERT_SVH

// Condition in the same cycle implies the consequent.
`define PTGB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel_tone_gray_blend: same-cycle check failed");

// Condition implies the consequent in the next cycle.
`define PTGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel_tone_gray_blend: next-cycle check failed");

`endif

@@ hdl/ptgb_pkg.sv @@
// Types, constants and helpers for the pixel tone and gray blend block.
// Standalone package; used by pixel_tone_gray_blend.
`timescale 1ns / 1ps

package ptgb_pkg;

   localparam int CHAN_W    = 8;
   localparam int OFFSET_W  = 9;
   localparam int GRAY_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CHANNELS  = 3;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_RED_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_OFFSET  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_AMOUNT  = 2'd3;

   // Luma weights, sum of weights times 255 fits 18 bits
   localparam int WSUM_W = 18;
   localparam logic [WSUM_W-1:0] LUMA_R_WEIGHT = 18'd299;
   localparam logic [WSUM_W-1:0] LUMA_G_WEIGHT = 18'd587;
   localparam logic [WSUM_W-1:0] LUMA_B_WEIGHT = 18'd114;

   // x / 1000 == (x * ceil(2^28 / 1000)) >> 28 for x below 2^18
   localparam int RECIP1000_W     = 19;
   localparam int RECIP1000_SHIFT = 28;
   localparam logic [RECIP1000_W-1:0] RECIP_1000 = 19'd268436;
   localparam int LUMA_PROD_W = WSUM_W + RECIP1000_W;

   // Blend sum (255 * 255 max) fits 16 bits
   localparam int BLEND_W = 16;
   localparam logic [GRAY_W-1:0] GRAY_FULL = 8'd255;

   // x / 255 == (x * ceil(2^24 / 255)) >> 24 for x up to 255 * 255
   localparam int RECIP255_W     = 17;
   localparam int RECIP255_SHIFT = 24;
   localparam logic [RECIP255_W-1:0] RECIP_255 = 17'd65794;
   localparam int BLEND_PROD_W = BLEND_W + RECIP255_W;

   typedef logic [CHANNELS-1:0][CHAN_W-1:0] rgb_type;
   typedef logic [CHANNELS-1:0][BLEND_W-1:0] blend_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic [CHAN_W-1:0] alpha_in;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] alpha_out;
   } rsp_payload_type;

   // Add a signed offset to a channel and clamp to 0..255
   function automatic logic [CHAN_W-1:0] tone_clamp(input logic [CHAN_W-1:0]   chan,
                                                    input logic [OFFSET_W-1:0] off);
      logic [CHAN_W+1:0] sum;
      sum = {2'b00, chan} + {off[OFFSET_W-1], off};
      if (sum[CHAN_W+1]) begin
         tone_clamp = '0;
      end else if (sum[CHAN_W]) begin
         tone_clamp = '1;
      end else begin
         tone_clamp = sum[CHAN_W-1:0];
      end
   endfunction

endpackage

@@ hdl/pixel_tone_gray_blend.sv @@
// Pixel tone offset and desaturation toward luma, five-stage pipeline.
// Depends on ptgb_pkg and pixel_tone_gray_blend_assert.svh.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   req      | in        | req_valid/req_ready  | req_payload (R, G, B, A)
//   rsp      | out       | rsp_valid/rsp_ready  | rsp_payload (R, G, B, A)
//   csr      | in        | csr_write_en         | csr_index, csr_wdata
//
// One pixel enters per cycle while req_ready is high; clamp, luma sum, divide by 1000,
// blend and divide by 255 register in stages 1 to 5 in order; rsp_valid is stage 5's valid.
// Each stage loads when it is empty or the stage after it moves, so a stall
// at rsp only backs up until bubbles are filled; req_ready drops when all
// five stages are full and rsp_ready is low.
// Synchronous reset empties the pipeline and clears all csr registers to 0.
`timescale 1ns / 1ps

module pixel_tone_gray_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ptgb_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ptgb_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_write_en,
   input  logic [ptgb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ptgb_pkg::OFFSET_W-1:0]     csr_wdata
);

   import ptgb_pkg::*;

   // csr registers
   logic [OFFSET_W-1:0] red_offset_ff;
   logic [OFFSET_W-1:0] green_offset_ff;
   logic [OFFSET_W-1:0] blue_offset_ff;
   logic [GRAY_W-1:0]   gray_amount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_offset_ff   <= '0;
         green_offset_ff <= '0;
         blue_offset_ff  <= '0;
         gray_amount_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RED_OFFSET:   red_offset_ff   <= csr_wdata;
            CSR_GREEN_OFFSET: green_offset_ff <= csr_wdata;
            CSR_BLUE_OFFSET:  blue_offset_ff  <= csr_wdata;
            CSR_GRAY_AMOUNT:  gray_amount_ff  <= csr_wdata[GRAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

   assign s5_ready  = !s5_valid_ff || rsp_ready;
   assign s4_ready  = !s4_valid_ff || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Stage 1: offset and clamp
   rgb_type           s1_color_in, s1_color_ff;
   logic [CHAN_W-1:0] s1_alpha_ff;

   assign s1_color_in[CH_RED]   = tone_clamp(req_payload.red_in,   red_offset_ff);
   assign s1_color_in[CH_GREEN] = tone_clamp(req_payload.green_in, green_offset_ff);
   assign s1_color_in[CH_BLUE]  = tone_clamp(req_payload.blue_in,  blue_offset_ff);

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_color_ff <= s1_color_in;
         s1_alpha_ff <= req_payload.alpha_in;
      end
   end

   // Stage 2: weighted luma sum
   logic [WSUM_W-1:0] s2_wsum_in, s2_wsum_ff;
   rgb_type           s2_color_ff;
   logic [CHAN_W-1:0] s2_alpha_ff;

   assign s2_wsum_in = WSUM_W'(s1_color_ff[CH_RED])   * LUMA_R_WEIGHT
                     + WSUM_W'(s1_color_ff[CH_GREEN]) * LUMA_G_WEIGHT
                     + WSUM_W'(s1_color_ff[CH_BLUE])  * LUMA_B_WEIGHT;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_wsum_ff  <= s2_wsum_in;
         s2_color_ff <= s1_color_ff;
         s2_alpha_ff <= s1_alpha_ff;
      end
   end

   // Stage 3: divide by 1000 through the reciprocal
   logic [LUMA_PROD_W-1:0] s3_prod;
   logic [CHAN_W-1:0]      s3_luma_ff;
   rgb_type                s3_color_ff;
   logic [CHAN_W-1:0]      s3_alpha_ff;

   assign s3_prod = LUMA_PROD_W'(s2_wsum_ff) * LUMA_PROD_W'(RECIP_1000);

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_luma_ff  <= s3_prod[RECIP1000_SHIFT +: CHAN_W];
         s3_color_ff <= s2_color_ff;
         s3_alpha_ff <= s2_alpha_ff;
      end
   end

   // Stage 4: blend each channel toward luma
   logic [GRAY_W-1:0] s4_keep;
   blend_type         s4_blend_in, s4_blend_ff;
   logic [CHAN_W-1:0] s4_alpha_ff;

   assign s4_keep = GRAY_FULL - gray_amount_ff;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s4_blend_in[ch] = BLEND_W'(s4_keep) * BLEND_W'(s3_color_ff[ch])
                         + BLEND_W'(gray_amount_ff) * BLEND_W'(s3_luma_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_blend_ff <= s4_blend_in;
         s4_alpha_ff <= s3_alpha_ff;
      end
   end

   // Stage 5: divide by 255 through the reciprocal, output register
   logic [CHANNELS-1:0][BLEND_PROD_W-1:0] s5_prod;
   rgb_type                               s5_color_ff;
   logic [CHAN_W-1:0]                     s5_alpha_ff;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s5_prod[ch] = BLEND_PROD_W'(s4_blend_ff[ch]) * BLEND_PROD_W'(RECIP_255);
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            s5_color_ff[ch] <= s5_prod[ch][RECIP255_SHIFT +: CHAN_W];
         end
         s5_alpha_ff <= s4_alpha_ff;
      end
   end

   assign rsp_valid             = s5_valid_ff;
   assign rsp_payload.red_out   = s5_color_ff[CH_RED];
   assign rsp_payload.green_out = s5_color_ff[CH_GREEN];
   assign rsp_payload.blue_out  = s5_color_ff[CH_BLUE];
   assign rsp_payload.alpha_out = s5_alpha_ff;

   // Checks
   `include "pixel_tone_gray_blend_assert.svh"

   `PTGB_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && s5_valid_ff && !rsp_ready)
   `PTGB_ASSERT_NOW(a_luma_in_range, clock, reset, s2_valid_ff,
      s3_prod[RECIP1000_SHIFT+CHAN_W] == 1'b0)
   `PTGB_ASSERT_NOW(a_blend_in_range, clock, reset, s4_valid_ff,
      s5_prod[CH_RED][RECIP255_SHIFT+CHAN_W] == 1'b0 &&
      s5_prod[CH_GREEN][RECIP255_SHIFT+CHAN_W] == 1'b0 &&
      s5_prod[CH_BLUE][RECIP255_SHIFT+CHAN_W] == 1'b0)
   `PTGB_ASSERT_NEXT(a_transfer_enters, clock, reset, req_valid && req_ready, s1_valid_ff)

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for pixel_tone_gray_blend: per-channel offset and clamp, luma blend.
// Depends on ptgb_pkg and the RTL. Expected pixels come from a local copy of the math.
`timescale 1ns / 1ps

module tb_top;
   import ptgb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RSP_HOLD_CYCLES = 100;
   localparam int SEGMENT_PIXELS  = 58;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RED_OFFSET;
   logic [OFFSET_W-1:0]  csr_wdata = '0;

   // Local copy of the csr registers
   logic [OFFSET_W-1:0] tone_offset [CHANNELS];
   logic [GRAY_W-1:0]   gray_weight;

   rsp_payload_type expected_pixels [$];
   int mismatch_count = 0;
   int send_idle_pct  = 7;
   int recv_idle_pct  = 52;
   int hold_requests  = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int stall_cycles   = 0;

   pixel_tone_gray_blend u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int clamp_tone(input logic [CHAN_W-1:0] chan,
                                     input logic [OFFSET_W-1:0] off);
      int sum;
      sum = int'(chan) + int'($signed(off));
      if (sum < 0) begin
         return 0;
      end else if (sum > 255) begin
         return 255;
      end
      return sum;
   endfunction

   function automatic rsp_payload_type toned_pixel(input req_payload_type px);
      rsp_payload_type res;
      int r, g, b, luma, w;
      r = clamp_tone(px.red_in, tone_offset[CH_RED]);
      g = clamp_tone(px.green_in, tone_offset[CH_GREEN]);
      b = clamp_tone(px.blue_in, tone_offset[CH_BLUE]);
      w = gray_weight;
      if (w != 0) begin
         luma = (r * 299 + g * 587 + b * 114) / 1000;
         r = ((255 - w) * r + w * luma) / 255;
         g = ((255 - w) * g + w * luma) / 255;
         b = ((255 - w) * b + w * luma) / 255;
      end
      res.red_out   = r[CHAN_W-1:0];
      res.green_out = g[CHAN_W-1:0];
      res.blue_out  = b[CHAN_W-1:0];
      res.alpha_out = px.alpha_in;
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   // Drop valid, let every pixel in flight come out, then write all four registers.
   task automatic program_tone(input logic [OFFSET_W-1:0] red_off,
                               input logic [OFFSET_W-1:0] green_off,
                               input logic [OFFSET_W-1:0] blue_off,
                               input logic [OFFSET_W-1:0] gray_word);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_RED_OFFSET;
      csr_wdata    <= red_off;
      @(posedge clock);
      csr_index    <= CSR_GREEN_OFFSET;
      csr_wdata    <= green_off;
      @(posedge clock);
      csr_index    <= CSR_BLUE_OFFSET;
      csr_wdata    <= blue_off;
      @(posedge clock);
      csr_index    <= CSR_GRAY_AMOUNT;
      csr_wdata    <= gray_word;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tone_offset[CH_RED]   = red_off;
      tone_offset[CH_GREEN] = green_off;
      tone_offset[CH_BLUE]  = blue_off;
      gray_weight           = gray_word[GRAY_W-1:0];
   endtask

   // Valid stays high after a transfer; only an idle gap lowers it.
   task automatic send_pixel(input req_payload_type px);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_pixels.push_back(toned_pixel(px));
   endtask

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   function automatic req_payload_type random_pixel();
      return req_payload_type'{random_channel(), random_channel(), random_channel(),
                               random_channel()};
   endfunction

   function automatic logic [OFFSET_W-1:0] random_offset();
      case ($urandom_range(6))
         0:       return 9'h100;   // -256
         1:       return 9'h101;   // -255
         2:       return 9'h0FF;   // +255
         3:       return '0;
         default: return OFFSET_W'($urandom_range(511));
      endcase
   endfunction

   function automatic logic [OFFSET_W-1:0] random_gray();
      case ($urandom_range(5))
         0:       return '0;
         1:       return 9'h0FF;
         2:       return OFFSET_W'($urandom_range(511));   // top bit is dropped
         default: return OFFSET_W'($urandom_range(255));
      endcase
   endfunction

   task automatic test_passthrough();
      program_tone('0, '0, '0, '0);
      send_pixel(req_payload_type'{8'h00, 8'h00, 8'h00, 8'h00});
      send_pixel(req_payload_type'{8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(req_payload_type'{8'hAA, 8'h55, 8'hAA, 8'h55});
      send_pixel(req_payload_type'{8'h55, 8'hAA, 8'h55, 8'hAA});
   endtask

   task automatic test_offset_extremes();
      // +255, -255 and -256 on the three channels
      program_tone(9'h0FF, 9'h101, 9'h100, '0);
      send_pixel(req_payload_type'{8'd0, 8'd255, 8'd255, 8'd7});
      send_pixel(req_payload_type'{8'd1, 8'd128, 8'd0, 8'd200});
      send_pixel(req_payload_type'{8'd255, 8'd0, 8'd0, 8'd0});
      // -1, +1, +128: sums right at the clamp edges
      program_tone(9'h1FF, 9'h001, 9'h080, '0);
      send_pixel(req_payload_type'{8'd0, 8'd255, 8'd127, 8'd1});
      send_pixel(req_payload_type'{8'd200, 8'd254, 8'd128, 8'd254});
   endtask

   task automatic test_gray_extremes();
      program_tone('0, '0, '0, 9'h0FF);
      send_pixel(req_payload_type'{8'd255, 8'd0, 8'd0, 8'd9});
      send_pixel(req_payload_type'{8'd0, 8'd255, 8'd0, 8'd90});
      send_pixel(req_payload_type'{8'd0, 8'd0, 8'd255, 8'd180});
      send_pixel(req_payload_type'{8'd255, 8'd255, 8'd255, 8'd255});
      program_tone(9'd30, 9'h1E2, '0, 9'h001);
      send_pixel(req_payload_type'{8'd240, 8'd20, 8'd99, 8'd3});
      send_pixel(req_payload_type'{8'd17, 8'd250, 8'd0, 8'd4});
      // upper bit of the write data is not part of the gray register
      program_tone('0, '0, '0, 9'h180);
      send_pixel(req_payload_type'{8'd10, 8'd200, 8'd60, 8'd5});
      send_pixel(req_payload_type'{8'd255, 8'd0, 8'd128, 8'd6});
      program_tone('0, '0, '0, 9'h100);
      send_pixel(req_payload_type'{8'd33, 8'd66, 8'd99, 8'd132});
   endtask

   task automatic test_random_stream();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 7;  recv_idle_pct = 52; end
            1:       begin send_idle_pct = 52; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            program_tone(random_offset(), random_offset(), random_offset(), random_gray());
            repeat (SEGMENT_PIXELS) send_pixel(random_pixel());
         end
      end
   endtask

   // Receiver stalls long enough to fill the pipeline and push back on req.
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_tone(random_offset(), random_offset(), random_offset(), random_gray());
      hold_requests++;
      repeat (40) send_pixel(random_pixel());
   endtask

   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_error($sformatf("result %h with no pixel pending", rsp_payload));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_payload.red_out !== want.red_out)
               report_error($sformatf("red_out %0d, want %0d", rsp_payload.red_out,
                                      want.red_out));
            if (rsp_payload.green_out !== want.green_out)
               report_error($sformatf("green_out %0d, want %0d", rsp_payload.green_out,
                                      want.green_out));
            if (rsp_payload.blue_out !== want.blue_out)
               report_error($sformatf("blue_out %0d, want %0d", rsp_payload.blue_out,
                                      want.blue_out));
            if (rsp_payload.alpha_out !== want.alpha_out)
               report_error($sformatf("alpha_out %0d, want %0d", rsp_payload.alpha_out,
                                      want.alpha_out));
         end
      end
   end

   // Count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] ERROR: no transfer for %0d cycles", $time, stall_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      tone_offset[CH_RED]   = '0;
      tone_offset[CH_GREEN] = '0;
      tone_offset[CH_BLUE]  = '0;
      gray_weight           = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_passthrough();
      test_offset_extremes();
      test_gray_extremes();
      test_random_stream();
      test_output_stall();

      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
